@@ design/sexpr_pkg.sv @@
// Shared types and character constants for the s-expression tokenizer.
package sexpr_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_CHAR   = 3'd0,
        KIND_END    = 3'd1,
        KIND_LBRACK = 3'd2,
        KIND_RBRACK = 3'd3,
        KIND_EOF    = 3'd4
    } kind_t;

    // Characters the scanner looks for
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // One result item as held in the output queue
    typedef struct packed {
        kind_t       kind;
        logic        is_number;
        logic [7:0]  lexeme_char;
        logic [8:0]  char_position;
        logic        was_truncated;
        logic [31:0] line_number;
        logic        last_of_step;
    } result_t;

endpackage

@@ design/sexpr_in_if.sv @@
// Input channel: one byte or end-of-input mark per item.
interface sexpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, char_in, end_of_input, input ready);
    modport sink   (input valid, char_in, end_of_input, output ready);
endinterface

@@ design/sexpr_out_if.sv @@
// Output channel: one token result per item.
interface sexpr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic        is_number;
    logic [7:0]  lexeme_char;
    logic [8:0]  char_position;
    logic        was_truncated;
    logic [31:0] line_number;
    logic        last_of_step;

    modport source (output valid, result_kind, is_number, lexeme_char, char_position,
                    was_truncated, line_number, last_of_step, input ready);
    modport sink   (input valid, result_kind, is_number, lexeme_char, char_position,
                    was_truncated, line_number, last_of_step, output ready);
endinterface

@@ design/sexpr_tokenizer.sv @@
// Streaming s-expression tokenizer: top level.
//
// Takes one byte (or an end-of-input mark) per item and produces zero, one or
// two result items: lexeme characters, lexeme ends, bracket tokens and end of
// input. Space, tab, CR, LF and ';' comments are skipped; LF counts lines. Each
// accepted item is decoded in the cycle it is accepted and its results are
// written into a three-entry output queue, so the block takes one item per
// cycle as long as the sink takes one result per cycle. The input is ready
// whenever at most one result waits in the queue; an item that yields two
// results (a delimiter that closes a lexeme and is a bracket, VT or FF, which
// then starts a new identifier, or end of input inside a lexeme) leaves one
// more result to drain, and if the sink stalls the input stalls once the queue
// holds two results. Lexemes store at most MAX_ID_LENGTH+1 characters; the
// rest are dropped and the end item reports the truncation.
module sexpr_tokenizer
    import sexpr_pkg::*;
#(
    parameter int MAX_ID_LENGTH = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    sexpr_in_if.sink     in_ch,
    sexpr_out_if.source  out_ch
);

    localparam int LEN_W   = $clog2(MAX_ID_LENGTH + 2);
    localparam int Q_DEPTH = 3;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_COLON   = 5'b00100,
        MODE_LEXEME  = 5'b01000,
        MODE_QUOTED  = 5'b10000
    } mode_t;

    // Scanner state
    mode_t             mode_reg, mode_next;
    logic              quote_bar_reg, quote_bar_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              num_reg, num_next;
    logic              trunc_reg, trunc_next;
    logic [31:0]       line_reg, line_next;

    // Results of the current item
    result_t           res [2];
    logic [1:0]        res_cnt;

    // Output queue
    result_t           q_reg [Q_DEPTH];
    result_t           q_next [Q_DEPTH];
    logic [1:0]        cnt_reg, cnt_next;

    logic              accept;
    logic              pop;
    logic [7:0]        c;

    assign c      = in_ch.char_in;
    assign in_ch.ready = (cnt_reg <= 2'd1);
    assign accept = in_ch.valid && in_ch.ready;
    assign pop    = out_ch.valid && out_ch.ready;

    // Decode one item: next state and up to two results
    always_comb
    begin
        logic        do_store;
        logic        do_idle;
        logic        white;
        logic        id_char;
        logic [31:0] pos_wide;
        logic [7:0]  quote_c;

        mode_next      = mode_reg;
        quote_bar_next = quote_bar_reg;
        len_next       = len_reg;
        num_next       = num_reg;
        trunc_next     = trunc_reg;
        line_next      = line_reg;
        res_cnt        = 2'd0;
        do_store       = 1'b0;
        do_idle        = 1'b0;
        pos_wide       = 32'(len_reg);
        for (int i = 0; i < 2; i++)
        begin
            res[i] = '0;
        end

        white   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        id_char = !white && (c != CH_LPAREN) && (c != CH_RPAREN)
                  && (c != CH_SEMI) && (c != CH_BAR);
        quote_c = quote_bar_reg ? CH_BAR : CH_DQUOTE;

        if (in_ch.end_of_input)
        begin
            // end of input closes any open lexeme
            case (mode_reg)
                MODE_COMMENT:
                begin
                    line_next = line_reg + 32'd1;
                end
                MODE_COLON, MODE_LEXEME, MODE_QUOTED:
                begin
                    res[res_cnt[0]].kind          = KIND_END;
                    res[res_cnt[0]].is_number     = num_reg;
                    res[res_cnt[0]].char_position = pos_wide[8:0];
                    res[res_cnt[0]].was_truncated = trunc_reg;
                    res[res_cnt[0]].line_number   = line_reg;
                    res_cnt = res_cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_IDLE;
            res[res_cnt[0]].kind        = KIND_EOF;
            res[res_cnt[0]].line_number = line_next;
            res_cnt = res_cnt + 2'd1;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        line_next = line_reg + 32'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COLON:
                begin
                    // byte after the colon is stored unconditionally
                    mode_next = MODE_LEXEME;
                    do_store  = 1'b1;
                end
                MODE_LEXEME:
                begin
                    if (id_char)
                    begin
                        do_store = 1'b1;
                    end
                    else
                    begin
                        res[res_cnt[0]].kind          = KIND_END;
                        res[res_cnt[0]].is_number     = num_reg;
                        res[res_cnt[0]].char_position = pos_wide[8:0];
                        res[res_cnt[0]].was_truncated = trunc_reg;
                        res[res_cnt[0]].line_number   = line_reg;
                        res_cnt = res_cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                MODE_QUOTED:
                begin
                    if (c == quote_c)
                    begin
                        res[res_cnt[0]].kind          = KIND_END;
                        res[res_cnt[0]].is_number     = num_reg;
                        res[res_cnt[0]].char_position = pos_wide[8:0];
                        res[res_cnt[0]].was_truncated = trunc_reg;
                        res[res_cnt[0]].line_number   = line_reg;
                        res_cnt   = res_cnt + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // byte handled as between tokens
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR))
                begin
                end
                else if (c == CH_LF)
                begin
                    line_next = line_reg + 32'd1;
                end
                else if (c == CH_SEMI)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if ((c == CH_LPAREN) || (c == CH_RPAREN))
                begin
                    res[res_cnt[0]].kind        = (c == CH_LPAREN) ? KIND_LBRACK : KIND_RBRACK;
                    res[res_cnt[0]].line_number = line_reg;
                    res_cnt = res_cnt + 2'd1;
                end
                else
                begin
                    len_next   = '0;
                    trunc_next = 1'b0;
                    num_next   = 1'b0;
                    if (c == CH_COLON)
                    begin
                        mode_next = MODE_COLON;
                    end
                    else if ((c == CH_BAR) || (c == CH_DQUOTE))
                    begin
                        mode_next      = MODE_QUOTED;
                        quote_bar_next = (c == CH_BAR);
                    end
                    else
                    begin
                        mode_next = MODE_LEXEME;
                        num_next  = (c >= CH_ZERO) && (c <= CH_NINE);
                        do_store  = 1'b1;
                    end
                end
            end

            // store one lexeme byte unless the limit was reached
            if (do_store && !trunc_next)
            begin
                pos_wide = 32'(len_next);
                res[res_cnt[0]].kind          = KIND_CHAR;
                res[res_cnt[0]].is_number     = num_next;
                res[res_cnt[0]].lexeme_char   = c;
                res[res_cnt[0]].char_position = pos_wide[8:0];
                res[res_cnt[0]].line_number   = line_next;
                res_cnt = res_cnt + 2'd1;
                if (len_next == LEN_W'(MAX_ID_LENGTH))
                begin
                    trunc_next = 1'b1;
                end
                len_next = len_next + LEN_W'(1);
            end
        end

        res[0].last_of_step = (res_cnt == 2'd1);
        res[1].last_of_step = (res_cnt == 2'd2);
    end

    // Output queue: shift on pop, append the item's results behind
    always_comb
    begin
        logic [1:0] base;

        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        base = cnt_reg - {1'b0, pop};
        if (accept)
        begin
            if (res_cnt != 2'd0)
            begin
                q_next[base] = res[0];
            end
            if (res_cnt == 2'd2)
            begin
                q_next[base + 2'd1] = res[1];
            end
        end
        cnt_next = base + (accept ? res_cnt : 2'd0);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            quote_bar_reg <= 1'b0;
            len_reg       <= '0;
            num_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            line_reg      <= 32'd1;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                quote_bar_reg <= quote_bar_next;
                len_reg       <= len_next;
                num_reg       <= num_next;
                trunc_reg     <= trunc_next;
                line_reg      <= line_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // Head of queue drives the output channel
    assign out_ch.valid         = (cnt_reg != 2'd0);
    assign out_ch.result_kind   = q_reg[0].kind;
    assign out_ch.is_number     = q_reg[0].is_number;
    assign out_ch.lexeme_char   = q_reg[0].lexeme_char;
    assign out_ch.char_position = q_reg[0].char_position;
    assign out_ch.was_truncated = q_reg[0].was_truncated;
    assign out_ch.line_number   = q_reg[0].line_number;
    assign out_ch.last_of_step  = q_reg[0].last_of_step;

endmodule
